@@ src/gbn_pkg.sv @@
// Shared types and constants for the go-back-N window controller.
`default_nettype none
package gbn_pkg;

	localparam int MAX_FRAMES = 1024;
	localparam int FRAME_W    = 11;
	localparam int SEQ_W      = 10;
	localparam int CNT_W      = 16;
	localparam int ROUND_W    = 8;
	localparam int WIN_W      = 5;
	localparam int WIN_MAX    = 16;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_OUTCOME = 1'b1;

	localparam logic REG_WINDOW_SIZE = 1'b0;
	localparam logic REG_MAX_ROUNDS  = 1'b1;

	typedef struct packed {
		logic [FRAME_W-1:0] window_base;
		logic [FRAME_W-1:0] expected_seq;
		logic [FRAME_W-1:0] next_index;
		logic [FRAME_W-1:0] window_end;
		logic [FRAME_W-1:0] total_frames;
		logic [ROUND_W-1:0] round_count;
		logic               round_had_error;
		logic               active;
		logic [CNT_W-1:0]   sent_counter;
		logic [CNT_W-1:0]   corrupt_counter;
		logic [CNT_W-1:0]   retrans_counter;
	} state_t;

	typedef struct packed {
		logic [SEQ_W-1:0]   send_seq;
		logic               ack_valid;
		logic [SEQ_W-1:0]   ack_seq;
		logic               in_order;
		logic               go_back;
		logic [ROUND_W-1:0] round_number;
		logic               done_res;
		logic               success;
		logic [CNT_W-1:0]   frames_sent;
		logic [CNT_W-1:0]   frames_corrupted;
		logic [CNT_W-1:0]   retransmissions;
	} res_t;

endpackage
`default_nettype wire

@@ src/gbn_step.sv @@
// Next-state and result logic for one word of the go-back-N controller.
`default_nettype none
module gbn_step
	import gbn_pkg::*;
(
	input  state_t             st,
	input  logic [WIN_W-1:0]   window_size,
	input  logic [ROUND_W-1:0] max_rounds,
	input  logic               cmd,
	input  logic [FRAME_W-1:0] frame_count,
	input  logic               crc_ok,
	input  logic [SEQ_W-1:0]   recv_seq,
	output state_t             st_next,
	output res_t               res
);

	logic [WIN_W-1:0]   eff_win;
	logic [FRAME_W-1:0] total_start;
	logic               good;
	logic [FRAME_W-1:0] exp_inc;
	logic [FRAME_W-1:0] base_new;
	logic               err_new;
	logic [FRAME_W-1:0] ni;
	logic [FRAME_W:0]   lim_sum;
	logic [FRAME_W-1:0] win_lim;
	logic [FRAME_W:0]   start_sum;
	logic [FRAME_W-1:0] start_lim;
	logic [CNT_W:0]     sent_sum;
	logic [CNT_W:0]     corr_sum;
	logic [CNT_W:0]     retr_sum;
	logic [FRAME_W-1:0] retr_amt;

	function automatic logic [FRAME_W-1:0] eff_win_ext(input logic [WIN_W-1:0] w);
		eff_win_ext = {{(FRAME_W-WIN_W){1'b0}}, w};
	endfunction

	always_comb begin
		if (window_size == '0) begin
			eff_win = WIN_W'(1);
		end else if (window_size > WIN_W'(WIN_MAX)) begin
			eff_win = WIN_W'(WIN_MAX);
		end else begin
			eff_win = window_size;
		end
	end

	assign total_start = (frame_count > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES) : frame_count;
	assign start_sum   = {1'b0, eff_win_ext(eff_win)};
	assign start_lim   = (start_sum < {1'b0, total_start}) ? start_sum[FRAME_W-1:0] : total_start;

	assign good     = crc_ok && ({1'b0, recv_seq} == st.expected_seq)
			&& (st.expected_seq < st.total_frames);
	assign exp_inc  = st.expected_seq + FRAME_W'(1);
	assign base_new = (good && (exp_inc > st.window_base)) ? exp_inc : st.window_base;
	assign err_new  = good ? st.round_had_error : 1'b1;
	assign ni       = st.next_index + FRAME_W'(1);
	assign lim_sum  = {1'b0, base_new} + {1'b0, eff_win_ext(eff_win)};
	assign win_lim  = (lim_sum < {1'b0, st.total_frames}) ? lim_sum[FRAME_W-1:0] : st.total_frames;
	assign retr_amt = win_lim - base_new;
	assign sent_sum = {1'b0, st.sent_counter} + (CNT_W+1)'(1);
	assign corr_sum = {1'b0, st.corrupt_counter} + (CNT_W+1)'(1);
	assign retr_sum = {1'b0, st.retrans_counter} + {{(CNT_W+1-FRAME_W){1'b0}}, retr_amt};

	always_comb begin
		st_next = st;
		res     = '0;
		if (cmd == CMD_START) begin
			st_next                 = '0;
			st_next.total_frames    = total_start;
			if ((total_start != '0) && (max_rounds != '0)) begin
				st_next.round_count = ROUND_W'(1);
				st_next.window_end  = start_lim;
				st_next.active      = 1'b1;
			end else begin
				res.done_res = 1'b1;
				res.success  = (total_start == '0);
			end
		end else if (st.active) begin
			st_next.sent_counter = sent_sum[CNT_W] ? '1 : sent_sum[CNT_W-1:0];
			if (good) begin
				st_next.expected_seq = exp_inc;
				res.in_order         = 1'b1;
				res.ack_valid        = 1'b1;
				res.ack_seq          = st.expected_seq[SEQ_W-1:0];
			end else begin
				if (!crc_ok) begin
					st_next.corrupt_counter = corr_sum[CNT_W] ? '1 : corr_sum[CNT_W-1:0];
				end
				if (st.expected_seq != '0) begin
					res.ack_valid = 1'b1;
					res.ack_seq   = st.expected_seq[SEQ_W-1:0] - SEQ_W'(1);
				end
			end
			st_next.window_base     = base_new;
			st_next.round_had_error = err_new;
			st_next.next_index      = ni;
			if (ni >= st.window_end) begin
				if ((base_new < st.total_frames) && err_new) begin
					st_next.retrans_counter = retr_sum[CNT_W] ? '1 : retr_sum[CNT_W-1:0];
					res.go_back             = 1'b1;
				end
				if ((base_new < st.total_frames) && (st.round_count < max_rounds)) begin
					st_next.round_count     = st.round_count + ROUND_W'(1);
					st_next.round_had_error = 1'b0;
					st_next.next_index      = base_new;
					st_next.window_end      = win_lim;
				end else begin
					st_next.active = 1'b0;
					res.done_res   = 1'b1;
					res.success    = (base_new >= st.total_frames);
				end
			end
		end
		res.send_seq         = st_next.active ? st_next.next_index[SEQ_W-1:0] : '0;
		res.round_number     = st_next.round_count;
		res.frames_sent      = st_next.sent_counter;
		res.frames_corrupted = st_next.corrupt_counter;
		res.retransmissions  = st_next.retrans_counter;
	end

endmodule
`default_nettype wire

@@ src/gbn_outq.sv @@
// Two-entry result buffer: output register with a skid register behind it.
`default_nettype none
module gbn_outq
	import gbn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic can_push,
	output logic head_valid,
	input  logic head_ready,
	output res_t head_res,
	output logic skid_valid
);

	logic head_v_q;
	logic skid_v_q;
	res_t head_q;
	res_t skid_q;
	logic pop;

	assign pop        = head_v_q && head_ready;
	assign can_push   = !skid_v_q;
	assign head_valid = head_v_q;
	assign head_res   = head_q;
	assign skid_valid = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push && (!head_v_q || pop)) begin
			head_v_q <= 1'b1;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end else if (pop) begin
			head_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (push && (!head_v_q || pop)) begin
			head_q <= push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule
`default_nettype wire

@@ src/go_back_n_window_control.sv @@
// Top level of the go-back-N window controller: state, configuration and result buffer.
//
//  Channel   Handshake              Fields
//  in        in_valid / in_ready    cmd, frame_count, crc_ok, recv_seq
//  out       out_valid / out_ready  send_seq .. retransmissions (eleven fields)
//  cfg       cfg_wr_en              cfg_index, cfg_wr_data
//
// Each accepted word updates the window state in the same clock edge and registers one
// result word in the output buffer; one word per cycle while out_ready is high.
// The state update is one pass of the next-state logic between the state registers.
// Reset clears all window state and counters and loads window size 4 and round limit 15.
// A stalled output fills the skid register; in_ready drops only when both are full.
`default_nettype none
module go_back_n_window_control
	import gbn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [FRAME_W-1:0] frame_count,
	input  logic               crc_ok,
	input  logic [SEQ_W-1:0]   recv_seq,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SEQ_W-1:0]   send_seq,
	output logic               ack_valid,
	output logic [SEQ_W-1:0]   ack_seq,
	output logic               in_order,
	output logic               go_back,
	output logic [ROUND_W-1:0] round_number,
	output logic               done_res,
	output logic               success,
	output logic [CNT_W-1:0]   frames_sent,
	output logic [CNT_W-1:0]   frames_corrupted,
	output logic [CNT_W-1:0]   retransmissions
);

	state_t             st_q;
	state_t             st_next;
	res_t               step_res;
	res_t               head_res;
	logic [WIN_W-1:0]   window_size_q;
	logic [ROUND_W-1:0] max_rounds_q;
	logic               accept;
	logic               skid_valid;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_W'(4);
			max_rounds_q  <= ROUND_W'(15);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WINDOW_SIZE: window_size_q <= cfg_wr_data[WIN_W-1:0];
				REG_MAX_ROUNDS:  max_rounds_q  <= cfg_wr_data[ROUND_W-1:0];
				default:         max_rounds_q  <= max_rounds_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	gbn_step u_step (
		.st          (st_q),
		.window_size (window_size_q),
		.max_rounds  (max_rounds_q),
		.cmd         (cmd),
		.frame_count (frame_count),
		.crc_ok      (crc_ok),
		.recv_seq    (recv_seq),
		.st_next     (st_next),
		.res         (step_res)
	);

	gbn_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_res   (step_res),
		.can_push   (in_ready),
		.head_valid (out_valid),
		.head_ready (out_ready),
		.head_res   (head_res),
		.skid_valid (skid_valid)
	);

	assign send_seq         = head_res.send_seq;
	assign ack_valid        = head_res.ack_valid;
	assign ack_seq          = head_res.ack_seq;
	assign in_order         = head_res.in_order;
	assign go_back          = head_res.go_back;
	assign round_number     = head_res.round_number;
	assign done_res         = head_res.done_res;
	assign success          = head_res.success;
	assign frames_sent      = head_res.frames_sent;
	assign frames_corrupted = head_res.frames_corrupted;
	assign retransmissions  = head_res.retransmissions;

	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid |-> out_valid)
		else $error("Skid register holds a word while the output register is empty.");

	a_index_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active |-> (st_q.next_index < st_q.window_end)
			&& (st_q.window_end <= st_q.total_frames))
		else $error("Send index is outside the current window.");

	a_base_tracks_expected: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.window_base == st_q.expected_seq) && (st_q.expected_seq <= st_q.total_frames))
		else $error("Window base and expected sequence diverged.");

	a_success_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && success) |-> done_res)
		else $error("Success reported on a word that did not finish the transmission.");

endmodule
`default_nettype wire

@@ bench/go_back_n_window_control_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the go-back-N window controller: directed table, random messages.
module go_back_n_window_control_tb;
	import gbn_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int LIMIT_CYCLES = 600000;
	localparam int RAND_WORDS   = 450;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 200;
	localparam int CNT_MAX      = (1 << CNT_W) - 1;

	typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

	typedef struct {
		row_op_t            op;
		logic               cmd;
		logic [FRAME_W-1:0] fcount;
		logic               crc;
		logic [SEQ_W-1:0]   seq;
		logic               reg_idx;
		logic [7:0]         reg_val;
		bit                 typed;
		res_t               want;
	} row_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic               cfg_index   = REG_WINDOW_SIZE;
	logic [7:0]         cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               cmd         = CMD_START;
	logic [FRAME_W-1:0] frame_count = '0;
	logic               crc_ok      = 1'b0;
	logic [SEQ_W-1:0]   recv_seq    = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [SEQ_W-1:0]   send_seq;
	logic               ack_valid;
	logic [SEQ_W-1:0]   ack_seq;
	logic               in_order;
	logic               go_back;
	logic [ROUND_W-1:0] round_number;
	logic               done_res;
	logic               success;
	logic [CNT_W-1:0]   frames_sent;
	logic [CNT_W-1:0]   frames_corrupted;
	logic [CNT_W-1:0]   retransmissions;

	// Shadow copy of the window state and the two registers.
	logic [WIN_W-1:0]   win_reg;
	logic [7:0]         round_limit;
	logic [FRAME_W-1:0] base_q;
	logic [FRAME_W-1:0] expect_q;
	logic [FRAME_W-1:0] next_q;
	logic [FRAME_W-1:0] wend_q;
	logic [FRAME_W-1:0] total_q;
	logic [ROUND_W-1:0] round_q;
	logic               err_q;
	logic               active_q;
	logic [CNT_W-1:0]   sent_q;
	logic [CNT_W-1:0]   corrupt_q;
	logic [CNT_W-1:0]   retrans_q;

	res_t due_results[$];
	row_t script[$];
	int   errors     = 0;
	int   cycles     = 0;
	int   live_words = 0;
	int   tx_calm    = 0;
	int   rx_calm    = 0;
	bit   hold_req   = 1'b0;
	bit   holding    = 1'b0;

	go_back_n_window_control u_dut (.*);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int eff_window();
		if (win_reg == 0) return 1;
		if (win_reg > WIN_MAX) return WIN_MAX;
		return int'(win_reg);
	endfunction

	function automatic int window_limit();
		int e;
		e = int'(base_q) + eff_window();
		return (e < int'(total_q)) ? e : int'(total_q);
	endfunction

	function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] a, int b);
		int s;
		s = int'(a) + b;
		return (s > CNT_MAX) ? '1 : s[CNT_W-1:0];
	endfunction

	// Opens the next round when frames remain and the limit allows; returns 1 when finished.
	function automatic bit open_round();
		if (base_q < total_q && round_q < round_limit) begin
			round_q  = round_q + 1'b1;
			err_q    = 1'b0;
			next_q   = base_q;
			wend_q   = FRAME_W'(window_limit());
			active_q = 1'b1;
			return 1'b0;
		end
		active_q = 1'b0;
		return 1'b1;
	endfunction

	function automatic res_t window_step(logic c, logic [FRAME_W-1:0] fc, logic ok,
			logic [SEQ_W-1:0] rs);
		res_t r;
		r = '0;
		if (c == CMD_START) begin
			total_q   = (fc > MAX_FRAMES) ? FRAME_W'(MAX_FRAMES) : fc;
			base_q    = '0;
			expect_q  = '0;
			next_q    = '0;
			wend_q    = '0;
			round_q   = '0;
			err_q     = 1'b0;
			sent_q    = '0;
			corrupt_q = '0;
			retrans_q = '0;
			if (open_round()) begin
				r.done_res = 1'b1;
				r.success  = (base_q >= total_q);
			end
		end else if (active_q) begin
			sent_q = sat_count(sent_q, 1);
			if (ok && {1'b0, rs} == expect_q && expect_q < total_q) begin
				expect_q    = expect_q + 1'b1;
				r.in_order  = 1'b1;
				r.ack_valid = 1'b1;
				r.ack_seq   = SEQ_W'(expect_q - 1'b1);
				if (expect_q > base_q) base_q = expect_q;
			end else begin
				if (!ok) corrupt_q = sat_count(corrupt_q, 1);
				err_q = 1'b1;
				if (expect_q > 0) begin
					r.ack_valid = 1'b1;
					r.ack_seq   = SEQ_W'(expect_q - 1'b1);
				end
			end
			next_q = next_q + 1'b1;
			if (next_q >= wend_q) begin
				if (base_q < total_q && err_q) begin
					retrans_q = sat_count(retrans_q, window_limit() - int'(base_q));
					r.go_back = 1'b1;
				end
				if (open_round()) begin
					r.done_res = 1'b1;
					r.success  = (base_q >= total_q);
				end
			end
		end
		r.send_seq         = active_q ? next_q[SEQ_W-1:0] : '0;
		r.round_number     = round_q;
		r.frames_sent      = sent_q;
		r.frames_corrupted = corrupt_q;
		r.retransmissions  = retrans_q;
		return r;
	endfunction

	function automatic res_t settled(logic [ROUND_W-1:0] rnd, logic fin, logic good);
		res_t r;
		r              = '0;
		r.round_number = rnd;
		r.done_res     = fin;
		r.success      = good;
		return r;
	endfunction

	function automatic void put_word(logic c, int fc, logic ok, int rs, bit typed = 1'b0,
			res_t want = '0);
		row_t row;
		row.op      = ROW_WORD;
		row.cmd     = c;
		row.fcount  = FRAME_W'(fc);
		row.crc     = ok;
		row.seq     = SEQ_W'(rs);
		row.reg_idx = REG_WINDOW_SIZE;
		row.reg_val = '0;
		row.typed   = typed;
		row.want    = want;
		script.push_back(row);
	endfunction

	function automatic void put_reg(logic idx, logic [7:0] val);
		row_t row;
		row.op      = ROW_REG;
		row.cmd     = CMD_START;
		row.fcount  = '0;
		row.crc     = 1'b0;
		row.seq     = '0;
		row.reg_idx = idx;
		row.reg_val = val;
		row.typed   = 1'b0;
		row.want    = '0;
		script.push_back(row);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_window();
		int r;
		logic [WIN_W-1:0] w;
		r = $urandom_range(0, 9);
		if (r == 0) w = '0;
		else if (r == 1) w = WIN_W'(1);
		else if (r == 2) w = WIN_W'(WIN_MAX);
		else if (r == 3) w = WIN_W'($urandom_range(WIN_MAX + 1, 31));
		else w = WIN_W'($urandom_range(1, 8));
		return {3'($urandom), w};
	endfunction

	function automatic logic [7:0] pick_limit();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd1;
		if (r == 2) return 8'd255;
		return 8'($urandom_range(2, 12));
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want_v);
		errors++;
		if (errors <= 100)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want_v);
	endtask

	task automatic check_word();
		res_t want;
		if (due_results.size() == 0) begin
			report("word with nothing outstanding", 0, 0);
			return;
		end
		want = due_results.pop_front();
		if (send_seq !== want.send_seq) report("send_seq", send_seq, want.send_seq);
		if (ack_valid !== want.ack_valid) report("ack_valid", ack_valid, want.ack_valid);
		if (ack_seq !== want.ack_seq) report("ack_seq", ack_seq, want.ack_seq);
		if (in_order !== want.in_order) report("in_order", in_order, want.in_order);
		if (go_back !== want.go_back) report("go_back", go_back, want.go_back);
		if (round_number !== want.round_number)
			report("round_number", round_number, want.round_number);
		if (done_res !== want.done_res) report("done_res", done_res, want.done_res);
		if (success !== want.success) report("success", success, want.success);
		if (frames_sent !== want.frames_sent)
			report("frames_sent", frames_sent, want.frames_sent);
		if (frames_corrupted !== want.frames_corrupted)
			report("frames_corrupted", frames_corrupted, want.frames_corrupted);
		if (retransmissions !== want.retransmissions)
			report("retransmissions", retransmissions, want.retransmissions);
	endtask

	task automatic send_word(logic c, logic [FRAME_W-1:0] fc, logic ok, logic [SEQ_W-1:0] rs,
			bit typed, res_t want);
		res_t predicted;
		int   gap;
		in_valid    <= 1'b1;
		cmd         <= c;
		frame_count <= fc;
		crc_ok      <= ok;
		recv_seq    <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_START || active_q) live_words++;
		if (live_words == HOLD_AT) hold_req = 1'b1;
		predicted = window_step(c, fc, ok, rs);
		due_results.push_back(typed ? want : predicted);
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 49) == 0) tx_calm = 40;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_WINDOW_SIZE) win_reg = val[WIN_W-1:0];
		else round_limit = val;
	endtask

	task automatic run_message();
		int                 r;
		int                 cap;
		int                 n;
		logic [FRAME_W-1:0] fc;
		logic               ok;
		logic [SEQ_W-1:0]   rs;
		r = $urandom_range(0, 19);
		if (r == 0) fc = '0;
		else if (r == 1) fc = FRAME_W'($urandom_range(MAX_FRAMES, 2047));
		else if (r == 2) fc = FRAME_W'($urandom_range(100, MAX_FRAMES - 1));
		else fc = FRAME_W'($urandom_range(1, 24));
		cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 80;
		send_word(CMD_START, fc, 1'($urandom), SEQ_W'($urandom), 1'b0, '0);
		n = 0;
		while (active_q && n < cap) begin
			ok = ($urandom_range(0, 7) != 0);
			r  = $urandom_range(0, 19);
			if (r == 0) rs = SEQ_W'($urandom);
			else if (r == 1) rs = expect_q[SEQ_W-1:0] + 1'b1;
			else rs = next_q[SEQ_W-1:0];
			send_word(CMD_OUTCOME, FRAME_W'($urandom), ok, rs, 1'b0, '0);
			n++;
		end
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3))
				send_word(CMD_OUTCOME, FRAME_W'($urandom), 1'($urandom), SEQ_W'($urandom),
					1'b0, '0);
		end
	endtask

	initial begin
		win_reg     = 5'd4;
		round_limit = 8'd15;
		void'(window_step(CMD_START, '0, 1'b0, '0));
		round_q = '0;

		put_word(CMD_OUTCOME, 0, 1'b1, 1023, 1'b1, '0);
		put_word(CMD_START, 0, 1'b0, 0, 1'b1, settled(8'd0, 1'b1, 1'b1));
		put_word(CMD_START, 2047, 1'b1, 1023, 1'b1, settled(8'd1, 1'b0, 1'b0));
		put_word(CMD_OUTCOME, 0, 1'b1, 0);
		put_word(CMD_OUTCOME, 0, 1'b0, 1);
		put_word(CMD_OUTCOME, 2047, 1'b1, 1023);
		put_word(CMD_OUTCOME, 0, 1'b1, 1);
		put_word(CMD_OUTCOME, 0, 1'b1, 2);
		put_word(CMD_START, 10, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b1, 0);
		put_reg(REG_MAX_ROUNDS, 8'd0);
		put_word(CMD_START, 5, 1'b1, 0, 1'b1, settled(8'd0, 1'b1, 1'b0));
		put_reg(REG_MAX_ROUNDS, 8'd1);
		put_reg(REG_WINDOW_SIZE, 8'd0);
		put_word(CMD_START, 1, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b1, 0);
		put_word(CMD_OUTCOME, 0, 1'b1, 0);
		put_reg(REG_WINDOW_SIZE, 8'hFF);
		put_reg(REG_MAX_ROUNDS, 8'hFF);
		put_word(CMD_START, 3, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b1, 0);
		put_word(CMD_OUTCOME, 0, 1'b1, 1);
		put_word(CMD_OUTCOME, 0, 1'b1, 2);
		put_reg(REG_WINDOW_SIZE, 8'd2);
		put_reg(REG_MAX_ROUNDS, 8'd2);
		put_word(CMD_START, 4, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b0, 1);
		put_word(CMD_OUTCOME, 0, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b0, 1);
		put_reg(REG_WINDOW_SIZE, 8'd17);
		put_reg(REG_MAX_ROUNDS, 8'd15);
		put_word(CMD_START, 20, 1'b0, 0);
		put_word(CMD_OUTCOME, 0, 1'b1, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].op == ROW_REG) begin
				drain();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_word(script[i].cmd, script[i].fcount, script[i].crc, script[i].seq,
					script[i].typed, script[i].want);
			end
		end

		while (live_words < RAND_WORDS) begin
			if (!hold_req && !holding && $urandom_range(0, 3) == 0) begin
				drain();
				if ($urandom_range(0, 1)) write_reg(REG_WINDOW_SIZE, pick_window());
				if ($urandom_range(0, 1)) write_reg(REG_MAX_ROUNDS, pick_limit());
			end
			run_message();
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && due_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		int gap;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				holding  = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
				gap = 0;
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
				if (rx_calm > 0) begin
					rx_calm--;
				end else begin
					gap = pick_gap();
					if ($urandom_range(0, 49) == 0) rx_calm = 60;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) check_word();
	end

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

endmodule
